// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/gbt_pkg.sv =====
// Package: types and codes of the graph traversal engine.
`timescale 1ns / 1ps
package gbt_pkg;

    typedef logic [7:0] vertex_t;
    typedef logic [1:0] status_t;

    typedef enum logic [2:0] {
        OP_ADD_VERTEX = 3'd0,
        OP_ADD_EDGE   = 3'd1,
        OP_DEL_EDGE   = 3'd2,
        OP_BFS        = 3'd3,
        OP_DFS        = 3'd4
    } op_t;

    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_DUP     = 2'd1;
    localparam status_t STAT_MISSING = 2'd2;
    localparam status_t STAT_FULL    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RESP,
        S_DEL_RD,
        S_DEL_CMP,
        S_SH_RD,
        S_SH_WR,
        S_W_POP,
        S_W_POPD,
        S_W_NRD,
        S_W_NCHK
    } state_t;

endpackage

// ===== hw/rtl/gbt_req_if.sv =====
// Interface: request channel (operation and vertex labels).
`timescale 1ns / 1ps
interface gbt_req_if;
    logic            valid;
    logic            ready;
    logic [2:0]      op;
    gbt_pkg::vertex_t vertex_a;
    gbt_pkg::vertex_t vertex_b;

    modport source (output valid, output op, output vertex_a, output vertex_b, input ready);
    modport sink   (input valid, input op, input vertex_a, input vertex_b, output ready);
endinterface

// ===== hw/rtl/gbt_rsp_if.sv =====
// Interface: response channel (visited vertex, status, last flag).
`timescale 1ns / 1ps
interface gbt_rsp_if;
    logic             valid;
    logic             ready;
    gbt_pkg::vertex_t vertex;
    gbt_pkg::status_t status;
    logic             last;

    modport source (output valid, output vertex, output status, output last, input ready);
    modport sink   (input valid, input vertex, input status, input last, output ready);
endinterface

// ===== hw/rtl/graph_bfs_dfs_traversal.sv =====
// Top level: graph store with breadth-first and depth-first walks.
//
//  channel | dir | beat
//  --------+-----+-----------------------------------------
//  req     | in  | op, vertex_a, vertex_b
//  rsp     | out | vertex, status, last (last on final beat)
//
// An edit runs from accept through S_EXEC and S_RESP back to idle; its beat is
// registered in S_RESP. Delete edge adds a scan of entries (S_DEL_RD, S_DEL_CMP)
// and a shift of later entries (S_SH_RD, S_SH_WR). A walk pops entries (S_W_POP,
// S_W_POPD) and reads neighbours (S_W_NRD, S_W_NCHK); the memory reads are registered.
// One request at a time; req.ready is high only when idle. rsp stalls hold the
// engine. Reset is immediate: no clearing pass.
`timescale 1ns / 1ps
module graph_bfs_dfs_traversal #(
    parameter int MAX_VERTICES = 16,
    parameter int MAX_DEGREE   = 8,
    parameter int STACK_DEPTH  = 32,
    parameter int QUEUE_DEPTH  = 128
) (
    input  logic clk,
    input  logic rst_n,
    gbt_req_if.sink   req,
    gbt_rsp_if.source rsp
);
    import gbt_pkg::*;

    localparam int IW    = $clog2(MAX_VERTICES);
    localparam int VC_W  = $clog2(MAX_VERTICES + 1);
    localparam int DC_W  = $clog2(MAX_DEGREE + 1);
    localparam int NA_W  = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int NDEP  = MAX_VERTICES * MAX_DEGREE;
    localparam int WD    = (STACK_DEPTH > QUEUE_DEPTH) ? STACK_DEPTH : QUEUE_DEPTH;
    localparam int WA_W  = $clog2(WD);
    localparam int WF_W  = $clog2(WD + 1);

    state_t           state_reg, state_next;
    op_t              op_reg;
    vertex_t          a_reg, b_reg;
    logic [VC_W-1:0]  vcnt_reg, vcnt_next;
    vertex_t          lbl_reg [MAX_VERTICES];
    logic [DC_W-1:0]  ncnt_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] vis_reg;
    status_t          stat_reg, stat_next;
    logic [DC_W-1:0]  j_reg, j_next;
    logic [IW-1:0]    cur_reg, cur_next;
    logic [WF_W-1:0]  fill_reg, fill_next;
    logic [WF_W-1:0]  head_reg, head_next;
    logic             pv_reg, pv_next;
    vertex_t          pvtx_reg, pvtx_next;
    logic             ov_reg;
    vertex_t          ovtx_reg;
    status_t          ostat_reg;
    logic             olast_reg;

    vertex_t          nbr_mem [NDEP];
    vertex_t          nbr_rd_reg;
    vertex_t          wl_mem [WD];
    vertex_t          wl_rd_reg;

    logic             lbl_we;
    logic             ncnt_we;
    logic [IW-1:0]    ncnt_wi;
    logic [DC_W-1:0]  ncnt_wd;
    logic             vis_clr, vis_set;
    logic             nbr_we, nbr_re;
    logic [NA_W-1:0]  nbr_wa, nbr_ra;
    vertex_t          nbr_wd;
    logic             wl_we, wl_re;
    logic [WA_W-1:0]  wl_wa, wl_ra;
    vertex_t          wl_wd;
    logic             emit;
    vertex_t          e_vtx;
    status_t          e_stat;
    logic             e_last;

    vertex_t          key1;
    logic             f1_hit, f2_hit;
    logic [IW-1:0]    f1_idx;
    logic             out_free;
    logic             is_dfs;
    logic             wl_empty;
    logic             wl_room;
    logic             f1_new;

    function automatic logic [NA_W-1:0] nbr_addr(input logic [IW-1:0] v,
                                                 input logic [DC_W-1:0] k);
        return NA_W'(32'(v) * MAX_DEGREE + 32'(k));
    endfunction

    assign out_free = !ov_reg || rsp.ready;
    assign is_dfs   = (op_reg == OP_DFS);
    assign wl_empty = is_dfs ? (fill_reg == '0) : (head_reg == fill_reg);
    assign wl_room  = is_dfs ? (32'(fill_reg) < STACK_DEPTH) : (32'(fill_reg) < QUEUE_DEPTH);

    always_comb
    begin
        case (state_reg)
            S_W_POPD: key1 = wl_rd_reg;
            S_W_NCHK: key1 = nbr_rd_reg;
            default:  key1 = a_reg;
        endcase
    end

    // label search over the vertex table, first match wins
    always_comb
    begin
        f1_hit = 1'b0;
        f1_idx = '0;
        f2_hit = 1'b0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if ((VC_W'(i) < vcnt_reg) && (lbl_reg[i] == key1))
            begin
                f1_hit = 1'b1;
                f1_idx = IW'(i);
            end
            if ((VC_W'(i) < vcnt_reg) && (lbl_reg[i] == b_reg))
            begin
                f2_hit = 1'b1;
            end
        end
    end

    assign f1_new = f1_hit && !vis_reg[f1_idx];

    always_comb
    begin
        state_next = state_reg;
        vcnt_next  = vcnt_reg;
        stat_next  = stat_reg;
        j_next     = j_reg;
        cur_next   = cur_reg;
        fill_next  = fill_reg;
        head_next  = head_reg;
        pv_next    = pv_reg;
        pvtx_next  = pvtx_reg;
        lbl_we     = 1'b0;
        ncnt_we    = 1'b0;
        ncnt_wi    = cur_reg;
        ncnt_wd    = '0;
        vis_clr    = 1'b0;
        vis_set    = 1'b0;
        nbr_we     = 1'b0;
        nbr_wa     = nbr_addr(cur_reg, j_reg);
        nbr_wd     = b_reg;
        nbr_re     = 1'b0;
        nbr_ra     = nbr_addr(cur_reg, j_reg);
        wl_we      = 1'b0;
        wl_wa      = fill_reg[WA_W-1:0];
        wl_wd      = nbr_rd_reg;
        wl_re      = 1'b0;
        wl_ra      = head_reg[WA_W-1:0];
        emit       = 1'b0;
        e_vtx      = '0;
        e_stat     = STAT_OK;
        e_last     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                case (op_reg)
                    OP_ADD_VERTEX:
                    begin
                        if (f1_hit)
                        begin
                            stat_next = STAT_DUP;
                        end
                        else if (32'(vcnt_reg) >= MAX_VERTICES)
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            lbl_we    = 1'b1;
                            ncnt_we   = 1'b1;
                            ncnt_wi   = vcnt_reg[IW-1:0];
                            ncnt_wd   = '0;
                            vcnt_next = vcnt_reg + 1'b1;
                            stat_next = STAT_OK;
                        end
                    end
                    OP_ADD_EDGE:
                    begin
                        if (!f1_hit || !f2_hit)
                        begin
                            stat_next = STAT_MISSING;
                        end
                        else if (32'(ncnt_reg[f1_idx]) >= MAX_DEGREE)
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            nbr_we    = 1'b1;
                            nbr_wa    = nbr_addr(f1_idx, ncnt_reg[f1_idx]);
                            nbr_wd    = b_reg;
                            ncnt_we   = 1'b1;
                            ncnt_wi   = f1_idx;
                            ncnt_wd   = ncnt_reg[f1_idx] + 1'b1;
                            stat_next = STAT_OK;
                        end
                    end
                    OP_DEL_EDGE:
                    begin
                        if (!f1_hit)
                        begin
                            stat_next = STAT_MISSING;
                        end
                        else
                        begin
                            cur_next   = f1_idx;
                            j_next     = '0;
                            state_next = S_DEL_RD;
                        end
                    end
                    OP_BFS, OP_DFS:
                    begin
                        vis_clr = 1'b1;
                        if (!f1_hit)
                        begin
                            stat_next = STAT_MISSING;
                        end
                        else
                        begin
                            wl_we      = 1'b1;
                            wl_wa      = '0;
                            wl_wd      = a_reg;
                            fill_next  = WF_W'(1);
                            head_next  = '0;
                            state_next = S_W_POP;
                        end
                    end
                    default:
                    begin
                        stat_next = STAT_MISSING;
                    end
                endcase
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_stat     = stat_reg;
                    state_next = S_IDLE;
                end
            end
            S_DEL_RD:
            begin
                if (j_reg < ncnt_reg[cur_reg])
                begin
                    nbr_re     = 1'b1;
                    state_next = S_DEL_CMP;
                end
                else
                begin
                    stat_next  = STAT_MISSING;
                    state_next = S_RESP;
                end
            end
            S_DEL_CMP:
            begin
                if (nbr_rd_reg == b_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_DEL_RD;
                end
            end
            S_SH_RD:
            begin
                if (DC_W'(j_reg + 1'b1) < ncnt_reg[cur_reg])
                begin
                    nbr_re     = 1'b1;
                    nbr_ra     = nbr_addr(cur_reg, DC_W'(j_reg + 1'b1));
                    state_next = S_SH_WR;
                end
                else
                begin
                    ncnt_we    = 1'b1;
                    ncnt_wi    = cur_reg;
                    ncnt_wd    = ncnt_reg[cur_reg] - 1'b1;
                    stat_next  = STAT_OK;
                    state_next = S_RESP;
                end
            end
            S_SH_WR:
            begin
                nbr_we     = 1'b1;
                nbr_wd     = nbr_rd_reg;
                j_next     = j_reg + 1'b1;
                state_next = S_SH_RD;
            end
            S_W_POP:
            begin
                if (wl_empty)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_vtx      = pvtx_reg;
                        pv_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    wl_re = 1'b1;
                    if (is_dfs)
                    begin
                        wl_ra     = WA_W'(fill_reg - 1'b1);
                        fill_next = fill_reg - 1'b1;
                    end
                    else
                    begin
                        head_next = head_reg + 1'b1;
                    end
                    state_next = S_W_POPD;
                end
            end
            S_W_POPD:
            begin
                if (!f1_new)
                begin
                    state_next = S_W_POP;
                end
                else if (!pv_reg || out_free)
                begin
                    if (pv_reg)
                    begin
                        emit   = 1'b1;
                        e_vtx  = pvtx_reg;
                        e_last = 1'b0;
                    end
                    pv_next    = 1'b1;
                    pvtx_next  = wl_rd_reg;
                    vis_set    = 1'b1;
                    cur_next   = f1_idx;
                    j_next     = '0;
                    state_next = S_W_NRD;
                end
            end
            S_W_NRD:
            begin
                if (j_reg < ncnt_reg[cur_reg])
                begin
                    nbr_re     = 1'b1;
                    state_next = S_W_NCHK;
                end
                else
                begin
                    state_next = S_W_POP;
                end
            end
            S_W_NCHK:
            begin
                if (f1_new && wl_room)
                begin
                    wl_we     = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                j_next     = j_reg + 1'b1;
                state_next = S_W_NRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = ov_reg;
    assign rsp.vertex = ovtx_reg;
    assign rsp.status = ostat_reg;
    assign rsp.last   = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vcnt_reg  <= '0;
            pv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            vis_reg   <= '0;
            fill_reg  <= '0;
            head_reg  <= '0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                ncnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            vcnt_reg  <= vcnt_next;
            pv_reg    <= pv_next;
            fill_reg  <= fill_next;
            head_reg  <= head_next;
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
            if (vis_clr)
            begin
                vis_reg <= '0;
            end
            else if (vis_set)
            begin
                vis_reg[f1_idx] <= 1'b1;
            end
            if (ncnt_we)
            begin
                ncnt_reg[ncnt_wi] <= ncnt_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.valid)
        begin
            op_reg <= op_t'(req.op);
            a_reg  <= req.vertex_a;
            b_reg  <= req.vertex_b;
        end
        stat_reg <= stat_next;
        j_reg    <= j_next;
        cur_reg  <= cur_next;
        pvtx_reg <= pvtx_next;
        if (emit)
        begin
            ovtx_reg  <= e_vtx;
            ostat_reg <= e_stat;
            olast_reg <= e_last;
        end
        if (lbl_we)
        begin
            lbl_reg[vcnt_reg[IW-1:0]] <= a_reg;
        end
    end

    // adjacency memory
    always_ff @(posedge clk)
    begin
        if (nbr_we)
        begin
            nbr_mem[nbr_wa] <= nbr_wd;
        end
        if (nbr_re)
        begin
            nbr_rd_reg <= nbr_mem[nbr_ra];
        end
    end

    // walk stack / queue memory
    always_ff @(posedge clk)
    begin
        if (wl_we)
        begin
            wl_mem[wl_wa] <= wl_wd;
        end
        if (wl_re)
        begin
            wl_rd_reg <= wl_mem[wl_ra];
        end
    end

endmodule

// ===== hw/rtl/gbt_checker.sv =====
// Checker: port-level properties of the traversal engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gbt_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input gbt_pkg::vertex_t rsp_vertex,
    input gbt_pkg::status_t rsp_status,
    input logic             rsp_last
);
    import gbt_pkg::*;

    `ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_vertex) && $stable(rsp_status) && $stable(rsp_last))
    `ASSERT_IMP(a_err_single, clk, rst_n, rsp_valid && rsp_status != STAT_OK, rsp_last && rsp_vertex == '0)
    `ASSERT_NXT(a_busy_after_beat, clk, rst_n, req_valid && req_ready, !req_ready)

endmodule

bind graph_bfs_dfs_traversal gbt_checker u_gbt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_vertex (rsp.vertex),
    .rsp_status (rsp.status),
    .rsp_last   (rsp.last)
);
